/* hw/rtl/txq_pkg.sv */
`timescale 1ns / 1ps
// types and constants shared by the transmit descriptor queue
// no dependencies; every txq module but txq_ram imports this package
package txq_pkg;

   typedef struct packed {
      logic        func;
      logic [15:0] msg_type;
      logic [31:0] msg_flags;
      logic [31:0] request_tag;
      logic [15:0] payload_length;
      logic [15:0] payload_handle;
      logic [63:0] now_us;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] out_type;
      logic [31:0] out_flags;
      logic [31:0] out_request;
      logic [31:0] out_sequence;
      logic [63:0] out_time;
      logic [15:0] out_length;
      logic [15:0] out_handle;
      logic        out_reliable;
      logic        freed_valid;
      logic [15:0] freed_handle;
   } rsp_item_type;

   // one queued descriptor as stored in the ring memory
   typedef struct packed {
      logic [15:0] msg_type;
      logic [31:0] flags;
      logic [31:0] request;
      logic [31:0] seq_num;
      logic [63:0] stamp;
      logic [15:0] length;
      logic [15:0] handle;
   } desc_type;

   localparam int DESC_W = $bits(desc_type);

   localparam logic [2:0] ST_QUEUED    = 3'd0;
   localparam logic [2:0] ST_EVICTED   = 3'd1;
   localparam logic [2:0] ST_DROPPED   = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_LINK_DOWN = 3'd4;
   localparam logic [2:0] ST_TOO_LONG  = 3'd5;
   localparam logic [2:0] ST_DEQUEUED  = 3'd6;
   localparam logic [2:0] ST_EMPTY     = 3'd7;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_LINK_UP     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPORT_TYPE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD = 2'd2;

   typedef enum logic [1:0] {
      RD_HEAD,
      RD_PTR,
      RD_PREV
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_TAIL,
      WR_HEAD,
      WR_SHIFT
   } wr_sel_type;

   typedef struct packed {
      logic       load_req;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       srch_init;
      logic       srch_next;
      logic       shift_step;
      logic       victim_load;
      logic       head_inc;
      logic       fill_inc;
      logic       fill_dec;
      logic       seq_inc;
      logic       resp_en;
      logic [2:0] resp_status;
   } cmd_type;

   typedef struct packed {
      logic is_deq;
      logic empty;
      logic link_up;
      logic too_long;
      logic full;
      logic hit;
      logic cnt_zero;
      logic srch_last;
      logic shift_last;
      logic req_is_report;
   } sts_type;

endpackage

/* hw/rtl/tx_queue_evict_unreliable_first_core.sv */
`timescale 1ns / 1ps
// Transmit descriptor queue with class-aware overflow.
// Commands: raise start with req_item while busy is low; func 0 enqueues a
// descriptor (stamped with the next sequence number and now_us), func 1 pops
// the head. Every accepted item gives exactly one result: rsp_strobe is high
// for one cycle with rsp_item. The receiver cannot stall; results are never
// held back. Configuration (link up, input report type, max payload) is to be
// written through csr_wr_en / csr_index / csr_wdata only while the block is idle;
// the block does not enforce this. A new item is taken only once the last one
// is done: busy stays high until its result is issued. An enqueue into a
// non-full ring, a reject and a pop of an empty ring are decoded, then issued;
// a pop of a queued descriptor is decoded with a ring read, then issued. An
// enqueue into a full ring walks the ring memory through its single read port:
// it searches entry by entry for the oldest input report and, if one is found,
// moves entries one by one to close the gap and then appends the new one.
// Reset clears the head pointer, fill count, sequence counter, link up, report
// type and result strobe, and sets max payload to 16'hFFFF; the ring memory
// needs no clearing since only occupied slots are read.
// depends on txq_pkg, txq_ctrl, txq_dpath
module tx_queue_evict_unreliable_first_core #(
   parameter int QUEUE_DEPTH = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  txq_pkg::req_item_type          req_item,
   output logic                           rsp_strobe,
   output txq_pkg::rsp_item_type          rsp_item,
   input  logic                           csr_wr_en,
   input  logic [txq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [txq_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import txq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   txq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   txq_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_item   (req_item),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

/* hw/rtl/txq_ram.sv */
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read data
// no dependencies
module txq_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/txq_ctrl.sv */
`timescale 1ns / 1ps
// sequencer of the transmit descriptor queue: decode, eviction search and shift
// depends on txq_pkg
module txq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  txq_pkg::sts_type sts,
   output txq_pkg::cmd_type cmd
);
   import txq_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_DECIDE   = 8'b0000_0010,
      S_DEQ_OUT  = 8'b0000_0100,
      S_SRCH_RD  = 8'b0000_1000,
      S_SRCH_CHK = 8'b0001_0000,
      S_SHIFT_RD = 8'b0010_0000,
      S_SHIFT_WR = 8'b0100_0000,
      S_EVICT    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (sts.is_deq) begin
               if (sts.empty) begin
                  cmd.resp_en     = 1'b1;
                  cmd.resp_status = ST_EMPTY;
                  state_in        = S_IDLE;
               end else begin
                  cmd.rd_sel = RD_HEAD;
                  state_in   = S_DEQ_OUT;
               end
            end else if (!sts.link_up) begin
               cmd.resp_en     = 1'b1;
               cmd.resp_status = ST_LINK_DOWN;
               state_in        = S_IDLE;
            end else if (sts.too_long) begin
               cmd.resp_en     = 1'b1;
               cmd.resp_status = ST_TOO_LONG;
               state_in        = S_IDLE;
            end else if (!sts.full) begin
               cmd.wr_en       = 1'b1;
               cmd.wr_sel      = WR_TAIL;
               cmd.fill_inc    = 1'b1;
               cmd.seq_inc     = 1'b1;
               cmd.resp_en     = 1'b1;
               cmd.resp_status = ST_QUEUED;
               state_in        = S_IDLE;
            end else begin
               cmd.srch_init = 1'b1;
               state_in      = S_SRCH_RD;
            end
         end
         S_DEQ_OUT: begin
            cmd.resp_en     = 1'b1;
            cmd.resp_status = ST_DEQUEUED;
            cmd.head_inc    = 1'b1;
            cmd.fill_dec    = 1'b1;
            state_in        = S_IDLE;
         end
         S_SRCH_RD: begin
            cmd.rd_sel = RD_PTR;
            state_in   = S_SRCH_CHK;
         end
         S_SRCH_CHK: begin
            if (sts.hit) begin
               cmd.victim_load = 1'b1;
               state_in        = sts.cnt_zero ? S_EVICT : S_SHIFT_RD;
            end else if (sts.srch_last) begin
               // no input report queued: drop a report, reject anything else
               cmd.resp_en     = 1'b1;
               cmd.resp_status = sts.req_is_report ? ST_DROPPED : ST_FULL;
               state_in        = S_IDLE;
            end else begin
               cmd.srch_next = 1'b1;
               state_in      = S_SRCH_RD;
            end
         end
         S_SHIFT_RD: begin
            cmd.rd_sel = RD_PREV;
            state_in   = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            cmd.wr_en      = 1'b1;
            cmd.wr_sel     = WR_SHIFT;
            cmd.shift_step = 1'b1;
            state_in       = sts.shift_last ? S_EVICT : S_SHIFT_RD;
         end
         S_EVICT: begin
            // old head slot becomes the new tail once the head moves on
            cmd.wr_en       = 1'b1;
            cmd.wr_sel      = WR_HEAD;
            cmd.head_inc    = 1'b1;
            cmd.seq_inc     = 1'b1;
            cmd.resp_en     = 1'b1;
            cmd.resp_status = ST_EVICTED;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   a_resp_not_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.resp_en |-> state_ff != S_IDLE)
      else $error("response issued from idle");

   a_start_decides: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && start) |=> state_ff == S_DECIDE)
      else $error("accepted item not decoded");

   a_shift_pairs: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT_WR |-> $past(state_ff) == S_SHIFT_RD)
      else $error("shift write without preceding read");

endmodule

/* hw/rtl/txq_dpath.sv */
`timescale 1ns / 1ps
// datapath of the transmit descriptor queue: ring memory, pointers, counters,
// configuration registers and result register; depends on txq_pkg and txq_ram
module txq_dpath #(
   parameter int QUEUE_DEPTH = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [txq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [txq_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  txq_pkg::req_item_type              req_item,
   input  txq_pkg::cmd_type                   cmd,
   output txq_pkg::sts_type                   sts,
   output logic                               rsp_strobe,
   output txq_pkg::rsp_item_type              rsp_item
);
   import txq_pkg::*;

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [AW-1:0] LAST     = AW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FILL_MAX = CW'(QUEUE_DEPTH);
   localparam logic [CW:0]   SUM_WRAP = (CW + 1)'(QUEUE_DEPTH);

   function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
      return (p == LAST) ? '0 : p + AW'(1);
   endfunction

   function automatic logic [AW-1:0] prev_pos(input logic [AW-1:0] p);
      return (p == '0) ? LAST : p - AW'(1);
   endfunction

   logic         link_up_ff, link_up_in;
   logic [15:0]  report_type_ff, report_type_in;
   logic [15:0]  max_payload_ff, max_payload_in;
   req_item_type req_ff, req_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [31:0]   seq_ff, seq_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [15:0]   victim_ff, victim_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   rsp_item_type  rsp_item_ff, rsp_item_in;

   logic [CW:0]       tail_sum;
   logic [CW:0]       tail_wrap;
   logic [AW-1:0]     tail_addr;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     wr_addr;
   logic [DESC_W-1:0] wr_data;
   logic [DESC_W-1:0] rd_data;
   desc_type          rd_desc;
   desc_type          new_desc;

   // tail = (head + fill) mod depth; the sum stays below twice the depth
   assign tail_sum  = (CW + 1)'(head_ff) + (CW + 1)'(fill_ff);
   assign tail_wrap = (tail_sum >= SUM_WRAP) ? tail_sum - SUM_WRAP : tail_sum;
   assign tail_addr = tail_wrap[AW-1:0];

   assign rd_desc = desc_type'(rd_data);

   always_comb begin
      new_desc.msg_type = req_ff.msg_type;
      new_desc.flags    = req_ff.msg_flags;
      new_desc.request  = req_ff.request_tag;
      new_desc.seq_num  = seq_ff + 32'd1;
      new_desc.stamp    = req_ff.now_us;
      new_desc.length   = req_ff.payload_length;
      new_desc.handle   = req_ff.payload_handle;
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_HEAD: rd_addr = head_ff;
         RD_PTR:  rd_addr = ptr_ff;
         RD_PREV: rd_addr = prev_pos(ptr_ff);
         default: rd_addr = head_ff;
      endcase
      case (cmd.wr_sel)
         WR_TAIL:  wr_addr = tail_addr;
         WR_HEAD:  wr_addr = head_ff;
         WR_SHIFT: wr_addr = ptr_ff;
         default:  wr_addr = tail_addr;
      endcase
      wr_data = (cmd.wr_sel == WR_SHIFT) ? rd_data : new_desc;
   end

   txq_ram #(
      .WIDTH (DESC_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      sts.is_deq        = req_ff.func;
      sts.empty         = (fill_ff == '0);
      sts.link_up       = link_up_ff;
      sts.too_long      = (req_ff.payload_length > max_payload_ff);
      sts.full          = (fill_ff == FILL_MAX);
      sts.hit           = (rd_desc.msg_type == report_type_ff);
      sts.cnt_zero      = (cnt_ff == '0);
      sts.srch_last     = (cnt_ff == LAST);
      sts.shift_last    = (cnt_ff == AW'(1));
      sts.req_is_report = (req_ff.msg_type == report_type_ff);
   end

   always_comb begin
      link_up_in     = link_up_ff;
      report_type_in = report_type_ff;
      max_payload_in = max_payload_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_LINK_UP:     link_up_in     = csr_wdata[0];
            CSR_REPORT_TYPE: report_type_in = csr_wdata;
            CSR_MAX_PAYLOAD: max_payload_in = csr_wdata;
            default: begin
            end
         endcase
      end

      req_in    = cmd.load_req ? req_item : req_ff;
      head_in   = cmd.head_inc ? next_pos(head_ff) : head_ff;
      seq_in    = cmd.seq_inc ? seq_ff + 32'd1 : seq_ff;
      victim_in = cmd.victim_load ? rd_desc.handle : victim_ff;

      fill_in = fill_ff;
      if (cmd.fill_inc) begin
         fill_in = fill_ff + CW'(1);
      end else if (cmd.fill_dec) begin
         fill_in = fill_ff - CW'(1);
      end

      ptr_in = ptr_ff;
      cnt_in = cnt_ff;
      if (cmd.srch_init) begin
         ptr_in = head_ff;
         cnt_in = '0;
      end else if (cmd.srch_next) begin
         ptr_in = next_pos(ptr_ff);
         cnt_in = cnt_ff + AW'(1);
      end else if (cmd.shift_step) begin
         ptr_in = prev_pos(ptr_ff);
         cnt_in = cnt_ff - AW'(1);
      end

      rsp_strobe_in = cmd.resp_en;
      rsp_item_in   = rsp_item_ff;
      if (cmd.resp_en) begin
         rsp_item_in        = '0;
         rsp_item_in.status = cmd.resp_status;
         case (cmd.resp_status)
            ST_DEQUEUED: begin
               rsp_item_in.out_type     = rd_desc.msg_type;
               rsp_item_in.out_flags    = rd_desc.flags;
               rsp_item_in.out_request  = rd_desc.request;
               rsp_item_in.out_sequence = rd_desc.seq_num;
               rsp_item_in.out_time     = rd_desc.stamp;
               rsp_item_in.out_length   = rd_desc.length;
               rsp_item_in.out_handle   = rd_desc.handle;
               rsp_item_in.out_reliable = (rd_desc.msg_type != report_type_ff);
            end
            ST_EVICTED: begin
               rsp_item_in.freed_valid  = 1'b1;
               rsp_item_in.freed_handle = victim_ff;
            end
            ST_DROPPED: begin
               rsp_item_in.freed_valid  = 1'b1;
               rsp_item_in.freed_handle = req_ff.payload_handle;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_up_ff     <= 1'b0;
         report_type_ff <= '0;
         max_payload_ff <= 16'hFFFF;
         head_ff        <= '0;
         fill_ff        <= '0;
         seq_ff         <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         link_up_ff     <= link_up_in;
         report_type_ff <= report_type_in;
         max_payload_ff <= max_payload_in;
         head_ff        <= head_in;
         fill_ff        <= fill_in;
         seq_ff         <= seq_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      ptr_ff      <= ptr_in;
      cnt_ff      <= cnt_in;
      victim_ff   <= victim_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_MAX)
      else $error("fill count beyond queue depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_dec |-> fill_ff != '0)
      else $error("pop from empty queue");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_en && cmd.wr_sel == WR_TAIL) |-> fill_ff != FILL_MAX)
      else $error("tail write into full ring");

endmodule

/* bench/tb_tx_queue_evict_unreliable_first_core.sv */
`timescale 1ns / 1ps
// self-checking bench for the transmit descriptor queue with class-aware overflow
// drives commands and register writes, predicts every result, checks it on the strobe
// depends on txq_pkg and tx_queue_evict_unreliable_first_core
module tb_tx_queue_evict_unreliable_first_core;
   import txq_pkg::*;

   localparam int RING_DEPTH  = 256;
   localparam int CYCLE_LIMIT = 8_000_000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_item_type          req_item = '0;
   logic                  rsp_strobe;
   rsp_item_type          rsp_item;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_LINK_UP;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state: live descriptors oldest first, plus register copies
   desc_type    model_ring[$];
   logic [31:0] seq_counter = '0;
   logic        cfg_link_up = 1'b0;
   logic [15:0] cfg_report_type = 16'h0000;
   logic [15:0] cfg_max_len = 16'hFFFF;

   req_item_type pending_q[$];
   rsp_item_type expected_outcomes[$];

   int items_pushed    = 0;
   int items_accepted  = 0;
   int results_checked = 0;
   int error_count     = 0;
   int settings_count  = 0;
   int cycle_count     = 0;
   int gap_left        = 0;
   int status_seen[8]  = '{default: 0};

   tx_queue_evict_unreliable_first_core #(
      .QUEUE_DEPTH(RING_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic rsp_item_type predict_outcome(req_item_type it);
      rsp_item_type r;
      desc_type     d;
      int           victim;
      r = '0;
      victim = -1;
      if (it.func) begin
         if (model_ring.size() == 0) begin
            r.status = ST_EMPTY;
         end else begin
            d = model_ring.pop_front();
            r.status       = ST_DEQUEUED;
            r.out_type     = d.msg_type;
            r.out_flags    = d.flags;
            r.out_request  = d.request;
            r.out_sequence = d.seq_num;
            r.out_time     = d.stamp;
            r.out_length   = d.length;
            r.out_handle   = d.handle;
            r.out_reliable = (d.msg_type != cfg_report_type);
         end
      end else if (!cfg_link_up) begin
         r.status = ST_LINK_DOWN;
      end else if (it.payload_length > cfg_max_len) begin
         r.status = ST_TOO_LONG;
      end else begin
         r.status = ST_QUEUED;
         if (model_ring.size() >= RING_DEPTH) begin
            // oldest input report gives up its slot, order of the rest is kept
            for (int i = 0; i < model_ring.size() && victim < 0; i++)
               if (model_ring[i].msg_type == cfg_report_type) victim = i;
            if (victim >= 0) begin
               r.status       = ST_EVICTED;
               r.freed_valid  = 1'b1;
               r.freed_handle = model_ring[victim].handle;
               model_ring.delete(victim);
            end else if (it.msg_type == cfg_report_type) begin
               r.status       = ST_DROPPED;
               r.freed_valid  = 1'b1;
               r.freed_handle = it.payload_handle;
            end else begin
               r.status = ST_FULL;
            end
         end
         if (r.status == ST_QUEUED || r.status == ST_EVICTED) begin
            seq_counter = seq_counter + 32'd1;
            d.msg_type = it.msg_type;
            d.flags    = it.msg_flags;
            d.request  = it.request_tag;
            d.seq_num  = seq_counter;
            d.stamp    = it.now_us;
            d.length   = it.payload_length;
            d.handle   = it.payload_handle;
            model_ring.push_back(d);
         end
      end
      return r;
   endfunction

   function automatic string describe(rsp_item_type r);
      return $sformatf({"st=%0d type=%h flags=%h req=%h seq=%h time=%h len=%h hdl=%h",
                        " rel=%b freed=%b/%h"},
                       r.status, r.out_type, r.out_flags, r.out_request, r.out_sequence,
                       r.out_time, r.out_length, r.out_handle, r.out_reliable,
                       r.freed_valid, r.freed_handle);
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic req_item_type make_enqueue(logic [15:0] mtype, logic [31:0] flags,
                                                 logic [31:0] tag, logic [15:0] len,
                                                 logic [15:0] handle, logic [63:0] now);
      req_item_type it;
      it.func           = 1'b0;
      it.msg_type       = mtype;
      it.msg_flags      = flags;
      it.request_tag    = tag;
      it.payload_length = len;
      it.payload_handle = handle;
      it.now_us         = now;
      return it;
   endfunction

   function automatic req_item_type random_dequeue();
      req_item_type it;
      // a pop ignores the descriptor fields, so they carry noise
      it = make_enqueue(16'($urandom), $urandom, $urandom, 16'($urandom), 16'($urandom),
                        {$urandom, $urandom});
      it.func = 1'b1;
      return it;
   endfunction

   function automatic req_item_type random_enqueue(int report_pct, int long_pct);
      req_item_type it;
      logic [15:0]  mtype;
      logic [15:0]  len;
      if ($urandom_range(0, 99) < report_pct) begin
         mtype = cfg_report_type;
      end else begin
         mtype = 16'($urandom);
         if (mtype == cfg_report_type) mtype = ~mtype;
      end
      if ($urandom_range(0, 99) < long_pct) len = 16'($urandom);
      else len = 16'($urandom_range(0, cfg_max_len));
      it = make_enqueue(mtype, $urandom, $urandom, len, 16'($urandom),
                        {$urandom, $urandom});
      return it;
   endfunction

   task automatic add_item(req_item_type it);
      pending_q.push_back(it);
      items_pushed++;
   endtask

   task automatic add_mix(int count, int enq_pct, int report_pct, int long_pct);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < enq_pct) add_item(random_enqueue(report_pct, long_pct));
         else add_item(random_dequeue());
      end
   endtask

   // called right after a rising edge; writes all three registers back to back
   task automatic apply_settings(logic link, logic [15:0] rtype, logic [15:0] max_len);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_LINK_UP;
      csr_wdata <= {15'd0, link};
      @(posedge clock);
      csr_index <= CSR_REPORT_TYPE;
      csr_wdata <= rtype;
      @(posedge clock);
      csr_index <= CSR_MAX_PAYLOAD;
      csr_wdata <= max_len;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_link_up     = link;
      cfg_report_type = rtype;
      cfg_max_len     = max_len;
      settings_count++;
   endtask

   task automatic wait_idle();
      while (items_accepted != items_pushed || expected_outcomes.size() != 0 || busy)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   always @(posedge clock) begin : drive_items
      logic drive_start;
      if (reset) begin
         start <= 1'b0;
      end else begin
         drive_start = start;
         if (start && !busy) begin
            expected_outcomes.push_back(predict_outcome(req_item));
            items_accepted++;
            drive_start = 1'b0;
         end
         if (!drive_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_q.size() != 0) begin
               req_item <= pending_q.pop_front();
               drive_start = 1'b1;
               gap_left = pick_gap();
            end
         end
         start <= drive_start;
      end
   end

   always @(posedge clock) begin : check_results
      rsp_item_type want;
      if (!reset && rsp_strobe) begin
         results_checked++;
         if (expected_outcomes.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("ERROR: result with no item outstanding: %s", describe(rsp_item));
         end else begin
            want = expected_outcomes.pop_front();
            status_seen[want.status]++;
            if (rsp_item !== want) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("ERROR: result %0d mismatch at %0t", results_checked, $realtime);
                  $display("  expected %s", describe(want));
                  $display("  actual   %s", describe(rsp_item));
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycle_count,
                  expected_outcomes.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : stimulus
      req_item_type all_ones;
      int           room;
      all_ones = '1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // out of reset: link down, empty ring
      add_item(all_ones);
      add_item(make_enqueue(16'h0001, 32'h1, 32'h2, 16'd10, 16'h0003, 64'd5));
      wait_idle();

      apply_settings(1'b1, 16'hFFFF, 16'd100);
      add_item(make_enqueue(16'h0002, '0, '0, 16'd101, 16'h0011, 64'd1));
      add_item(make_enqueue(16'hFFFF, '1, '1, 16'd100, 16'hFFFF, '1));
      add_item(make_enqueue(16'h0000, '0, '0, 16'd0, 16'h0000, '0));
      add_item(make_enqueue(16'h0002, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 16'hFFFF, 16'h0002,
                            64'h0123_4567_89AB_CDEF));
      add_item(random_dequeue());
      add_item(random_dequeue());
      add_item(random_dequeue());
      add_item(make_enqueue(16'h1234, 32'h0BAD_F00D, 32'h7, 16'd64, 16'h4321, 64'd99));
      wait_idle();

      // link drops with one descriptor queued: it must survive and still pop
      apply_settings(1'b0, 16'h0000, 16'h0000);
      add_item(make_enqueue(16'h0000, '0, '0, 16'd5, 16'h0005, 64'd7));
      add_item(random_dequeue());
      add_item(random_dequeue());
      wait_idle();

      apply_settings(1'b1, 16'h0000, 16'h0000);
      add_item(make_enqueue(16'h0000, 32'h8, 32'h9, 16'd1, 16'h000A, 64'd11));
      add_item(make_enqueue(16'h0000, 32'h8, 32'h9, 16'd0, 16'h000B, 64'd12));
      add_item(random_dequeue());
      add_item(make_enqueue(16'h8000, 32'hC, 32'hD, 16'd0, 16'h000E, 64'd13));
      add_item(random_dequeue());
      wait_idle();

      // light traffic, ring stays shallow
      apply_settings(1'b1, 16'h5A5A, 16'hFFFF);
      add_mix(300, 55, 30, 10);
      wait_idle();

      // fill up, then churn at full with reports around to evict
      apply_settings(1'b1, 16'h0000, 16'd1500);
      add_mix(280, 100, 20, 10);
      add_mix(250, 65, 20, 10);
      wait_idle();

      // full ring holding no report: reports are dropped, the rest rejected
      apply_settings(1'b1, 16'hFFFF, 16'hFFFF);
      room = RING_DEPTH - model_ring.size();
      add_mix(room, 100, 0, 0);
      add_mix(80, 100, 40, 15);
      wait_idle();

      apply_settings(1'b0, 16'hFFFF, 16'hFFFF);
      add_mix(60, 50, 30, 10);
      wait_idle();

      apply_settings(1'b1, 16'h00FF, 16'h0000);
      add_mix(150, 40, 30, 15);
      wait_idle();

      apply_settings(1'b1, 16'($urandom_range(1, 65534)), 16'($urandom_range(256, 65534)));
      add_mix(300, 75, 35, 10);
      wait_idle();

      // drain to empty, then mixed traffic with many reports
      apply_settings(1'b1, 16'($urandom_range(1, 65534)), 16'hFFFF);
      add_mix(model_ring.size() + 3, 0, 0, 0);
      add_mix(200, 50, 50, 10);
      wait_idle();
      repeat (10) @(posedge clock);

      if (expected_outcomes.size() != 0) begin
         $display("ERROR: %0d results never arrived", expected_outcomes.size());
         error_count += expected_outcomes.size();
      end
      $display("%0d items over %0d register settings, %0d results checked, %0d errors",
               items_accepted, settings_count, results_checked, error_count);
      $display({"outcomes: queued %0d, evicted %0d, dropped %0d, full %0d, link down %0d,",
                " too long %0d, popped %0d, empty %0d"},
               status_seen[ST_QUEUED], status_seen[ST_EVICTED], status_seen[ST_DROPPED],
               status_seen[ST_FULL], status_seen[ST_LINK_DOWN], status_seen[ST_TOO_LONG],
               status_seen[ST_DEQUEUED], status_seen[ST_EMPTY]);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* tx_queue_evict_unreliable_first_core.f */
hw/rtl/txq_pkg.sv
hw/rtl/txq_ram.sv
hw/rtl/txq_ctrl.sv
hw/rtl/txq_dpath.sv
hw/rtl/tx_queue_evict_unreliable_first_core.sv
bench/tb_tx_queue_evict_unreliable_first_core.sv
